FILE: rtl/core/plucked_string_additive_synth_core_macros.svh
// ----------------------------------------------------------------------------
// plucked string synth core assertion macros
// concurrent checks, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef PLUCKED_STRING_ADDITIVE_SYNTH_CORE_MACROS_SVH
`define PLUCKED_STRING_ADDITIVE_SYNTH_CORE_MACROS_SVH
`ifndef SYNTH
`define PSAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("psas check failed");
`define PSAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("psas check failed");
`else
`define PSAS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/psas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psas_pkg
// constants and helpers for the plucked string additive synth core
// ----------------------------------------------------------------------------
package psas_pkg;

    localparam int MAXH  = 16;
    localparam int ENV_W = 31;
    localparam int MAG_W = 32;

    typedef logic [31:0] t_mult_tab [MAXH];

    localparam logic [63:0] ONE30      = 64'd1073741824;
    localparam logic [30:0] ENV_ONE    = 31'd1073741824;
    localparam logic [30:0] FLAT30     = 31'd1070645210;
    localparam logic [22:0] GLIDE_SPAN = 23'd6202184;
    localparam logic [13:0] GAIN16     = 14'd9830;

    localparam logic [63:0] SA1 = 64'd1686629713;
    localparam logic [63:0] SA3 = 64'd693598670;
    localparam logic [63:0] SA5 = 64'd85569305;
    localparam logic [63:0] SA7 = 64'd5026995;
    localparam logic [63:0] SA9 = 64'd172272;

    localparam logic [30:0] START_AMP [MAXH] = '{
        31'd858993459, 31'd1073741824, 31'd858993459, 31'd429496730,
        31'd429496730, 31'd429496730, 31'd214748365, 31'd107374182,
        31'd107374182, 31'd107374182, 31'd107374182, 31'd107374182,
        31'd107374182, 31'd107374182, 31'd107374182, 31'd107374182};

    // decay rates in half-nepers per second
    localparam logic [4:0] DECAY_HALF [MAXH] = '{
        5'd3, 5'd4, 5'd5, 5'd6, 5'd6, 5'd6, 5'd10, 5'd12,
        5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12};
    localparam logic [4:0] PITCH_HALF = 5'd16;

    localparam logic [3:0]  FLAT_PARTIAL  = 4'd6;
    localparam logic [28:0] SEVENTH_RATIO = 29'd115356300;

    localparam logic REG_FPS      = 1'b0;
    localparam logic REG_NOTE_LEN = 1'b1;

    // harmonic ratio in q5.24
    function automatic logic [28:0] ratio24(input logic [3:0] k);
        if (k == FLAT_PARTIAL) begin
            return SEVENTH_RATIO;
        end
        return {5'({1'b0, k}) + 5'd1, 24'd0};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/plucked_string_additive_synth_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plucked_string_additive_synth_core
// additive oscillator bank giving one plucked string sample per input item
// ----------------------------------------------------------------------------
// Each input item is a sample tick and yields one signed q1.15 sample and a
// note_done flag. Per-harmonic phase and envelope live in a simple dual-port
// state memory that is swept once per item, one harmonic a cycle through a
// short read-modify-write pipeline, followed by the gain stage. An item's
// result is presented before the next item is taken. While the attack or
// release ramp is active, each ramp adds a reciprocal-multiply division by
// the constant ramp length. A finished note skips the sweep and goes from
// acceptance straight to the output state. A result held by the receiver
// holds the core.
// Configuration is written over the apb port at 0 (phase step) and 4 (note
// length) and is read back at the same addresses.
`include "plucked_string_additive_synth_core_macros.svh"
module plucked_string_additive_synth_core #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int HARMONICS        = 12,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int ATTACK_SAMPLES   = 240,
    parameter int RELEASE_SAMPLES  = 2400
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample,
    output logic               o_note_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import psas_pkg::*;

    localparam int KW     = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int IW     = $clog2(SINE_TABLE_DEPTH);
    localparam int PB     = PHASE_BITS;
    localparam int ACC_W  = 54;
    localparam int ATT_W  = $clog2(ATTACK_SAMPLES + 1);
    localparam int REL_W  = $clog2(RELEASE_SAMPLES + 1);
    localparam int FW     = (ATT_W > REL_W) ? ATT_W : REL_W;
    localparam logic [KW-1:0] K_LAST = KW'(HARMONICS - 1);
    localparam logic [32:0] ATT_RCP = 33'((64'd1 << 32) / 64'(ATTACK_SAMPLES));
    localparam logic [32:0] REL_RCP = 33'((64'd1 << 32) / 64'(RELEASE_SAMPLES));

    typedef logic signed [16:0] t_sine_rom [SINE_TABLE_DEPTH];

    typedef enum logic [3:0] {
        S_IDLE, S_FACT, S_FS, S_RUN, S_MAG, S_GAIN, S_SEL, S_DQ, S_DR, S_DM,
        S_ROUND, S_OUT
    } t_state;

    function automatic logic [31:0] decay_mult(input logic [4:0] halves);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] m;
        x  = ({59'd0, halves} << 31) / 64'(SAMPLE_RATE);
        x2 = (x * x) >> 32;
        x3 = (x2 * x) >> 32;
        m  = (64'd1 << 32) - x + x2 / 64'd2 - x3 / 64'd6;
        return m[31:0];
    endfunction

    function automatic t_mult_tab build_mult();
        t_mult_tab tab;
        for (int k = 0; k < MAXH; k++) begin
            tab[k] = decay_mult(DECAY_HALF[k]);
        end
        return tab;
    endfunction

    function automatic logic signed [16:0] sine15(input logic [63:0] idx);
        logic [63:0] u;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] s;
        logic [63:0] v;
        u = (idx << 32) / 64'(SINE_TABLE_DEPTH);
        y = {34'd0, u[29:0]};
        if (u[30]) begin
            y = ONE30 - y;
        end
        y2 = (y * y) >> 30;
        s  = SA9;
        s  = SA7 - ((y2 * s) >> 30);
        s  = SA5 - ((y2 * s) >> 30);
        s  = SA3 - ((y2 * s) >> 30);
        s  = SA1 - ((y2 * s) >> 30);
        v  = (y * s) >> 30;
        v  = (v + 64'd16384) >> 15;
        if (u[31]) begin
            return 17'(64'd0 - v);
        end
        return 17'(v);
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine15(64'(i));
        end
        return rom;
    endfunction

    localparam t_mult_tab   ENV_MULT   = build_mult();
    localparam logic [31:0] PITCH_MULT = decay_mult(PITCH_HALF);
    localparam t_sine_rom   SINE_ROM   = build_sine();

    t_state                    r_state;
    logic [22:0]               r_fps;
    logic [23:0]               r_note_len;
    logic [23:0]               r_cnt;
    logic [ENV_W-1:0]          r_penv;
    logic [HARMONICS-1:0]      r_vbit;
    logic [30:0]               r_factor;
    logic [23:0]               r_fs;
    logic                      r_iss;
    logic [KW-1:0]             r_k;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_v4;
    logic [PB-1:0]             r_s1_step;
    logic [KW-1:0]             r_s1_k;
    logic [PB+ENV_W-1:0]       r_rd;
    logic                      r_rd_vld;
    logic [PB-1:0]             r_s2_ph;
    logic [ENV_W-1:0]          r_s2_env;
    logic [KW-1:0]             r_s2_k;
    logic signed [16:0]        r_sin;
    logic [ENV_W-1:0]          r_s3_env;
    logic signed [48:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic [34:0]               r_mag35;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_att;
    logic                      r_rel;
    logic [MAG_W-1:0]          r_div_n;
    logic [FW-1:0]             r_div_den;
    logic [32:0]               r_div_rcp;
    logic [FW-1:0]             r_div_fac;
    logic [MAG_W-1:0]          r_div_q;
    logic [MAG_W-1:0]          r_div_a;
    logic [FW-1:0]             r_div_b;
    logic [MAG_W-1:0]          r_div_hi;
    logic                      r_div_ph;
    logic [15:0]               r_res_sample;
    logic                      r_res_done;
    logic                      r_out_valid;
    logic [15:0]               r_sample;
    logic                      r_done;
    logic [PB+ENV_W-1:0]       r_mem [HARMONICS];

    logic                      in_accept;
    logic                      cfg_wr;
    logic [23:0]               cnt_start;
    logic [53:0]               fac_prod;
    logic [53:0]               fs_prod;
    logic [52:0]               step_prod;
    logic [PB-1:0]             n_step;
    logic [PB-1:0]             rd_ph;
    logic [ENV_W-1:0]          rd_env;
    logic [PB-1:0]             n_phase;
    logic [PB+IW:0]            idx_prod;
    logic [IW-1:0]             idx;
    logic [62:0]               env_prod;
    logic [ENV_W-1:0]          n_env;
    logic [62:0]               pitch_prod;
    logic [ACC_W-1:0]          acc_abs;
    logic [48:0]               gain_prod;
    logic                      att_now;
    logic                      rel_now;
    logic [23:0]               rel_diff;
    logic [64:0]               est_prod;
    logic [MAG_W:0]            qd_prod;
    logic [MAG_W:0]            div_rem;
    logic [MAG_W:0]            div_rem_sub;
    logic                      div_ge;
    logic [MAG_W-1:0]          div_q;
    logic [FW-1:0]             div_r;
    logic [MAG_W+FW-1:0]       hi_prod;
    logic [2*FW-1:0]           lo_prod;
    logic [32:0]               rnd;
    logic [17:0]               rnd_q;
    logic [17:0]               rnd_lim;
    logic [15:0]               n_res_sample;

    assign in_accept = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign cnt_start = i_restart ? 24'd0 : r_cnt;

    assign fac_prod  = 54'(GLIDE_SPAN) * 54'(r_penv);
    assign fs_prod   = 54'(r_fps) * 54'(r_factor);
    assign step_prod = 53'(r_fs) * 53'(ratio24(4'(r_k)));
    assign n_step    = PB'(step_prod[52:24]);

    assign rd_ph   = r_rd_vld ? r_rd[PB+ENV_W-1:ENV_W] : '0;
    assign rd_env  = r_rd_vld ? r_rd[ENV_W-1:0] : START_AMP[4'(r_s1_k)];
    assign n_phase = rd_ph + r_s1_step;

    assign idx_prod = (PB+IW+1)'(r_s2_ph) * (PB+IW+1)'(SINE_TABLE_DEPTH);
    assign idx      = idx_prod[PB +: IW];
    assign env_prod = 63'(r_s2_env) * 63'(ENV_MULT[4'(r_s2_k)]);
    assign n_env    = env_prod[62:32];

    assign pitch_prod = 63'(r_penv) * 63'(PITCH_MULT);
    assign acc_abs    = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign gain_prod  = 49'(r_mag35) * 49'(GAIN16);
    assign att_now    = r_cnt < 24'(ATTACK_SAMPLES);
    assign rel_now    = (25'(r_cnt) + 25'(RELEASE_SAMPLES)) > 25'(r_note_len);
    assign rel_diff   = r_note_len - r_cnt;

    // quotient estimate by reciprocal, at most one short
    assign est_prod    = 65'(r_div_n) * 65'(r_div_rcp);
    assign qd_prod     = (MAG_W+1)'(r_div_q) * (MAG_W+1)'(r_div_den);
    assign div_rem     = (MAG_W+1)'(r_div_n) - qd_prod;
    assign div_rem_sub = div_rem - (MAG_W+1)'(r_div_den);
    assign div_ge      = div_rem >= (MAG_W+1)'(r_div_den);
    assign div_q       = r_div_q + MAG_W'(div_ge);
    assign div_r       = div_ge ? FW'(div_rem_sub) : FW'(div_rem);
    assign hi_prod     = (MAG_W+FW)'(r_div_a) * (MAG_W+FW)'(r_div_fac);
    assign lo_prod     = (2*FW)'(r_div_b) * (2*FW)'(r_div_fac);

    assign rnd   = 33'(r_mag) + 33'd16384;
    assign rnd_q = rnd[32:15];

    always_comb begin
        if (r_neg) begin
            rnd_lim      = (rnd_q > 18'd32768) ? 18'd32768 : rnd_q;
            n_res_sample = 16'(18'd0 - rnd_lim);
        end else begin
            rnd_lim      = (rnd_q > 18'd32767) ? 18'd32767 : rnd_q;
            n_res_sample = rnd_lim[15:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FPS:      prdata = {9'd0, r_fps};
            REG_NOTE_LEN: prdata = {8'd0, r_note_len};
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_note_done = r_done;

    // state memory, one entry per harmonic
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_k];
        if (r_v2) begin
            r_mem[r_s2_k] <= {r_s2_ph, n_env};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fps       <= 23'd160000;
            r_note_len  <= 24'd48000;
            r_cnt       <= '0;
            r_penv      <= ENV_ONE;
            r_vbit      <= '0;
            r_iss       <= 1'b0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_att       <= 1'b0;
            r_rel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_FPS:      r_fps      <= pwdata[22:0];
                    REG_NOTE_LEN: r_note_len <= pwdata[23:0];
                endcase
            end

            // harmonic sweep pipeline
            r_v1 <= r_iss;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_iss) begin
                r_k <= (r_k == K_LAST) ? '0 : r_k + 1'b1;
                if (r_k == K_LAST) begin
                    r_iss <= 1'b0;
                end
            end
            r_rd_vld  <= r_vbit[r_k];
            r_s1_step <= n_step;
            r_s1_k    <= r_k;
            r_s2_ph   <= n_phase;
            r_s2_env  <= rd_env;
            r_s2_k    <= r_s1_k;
            r_sin     <= SINE_ROM[idx];
            r_s3_env  <= r_s2_env;
            r_prod    <= $signed({1'b0, r_s3_env}) * r_sin;
            if (r_v2) begin
                r_vbit[r_s2_k] <= 1'b1;
            end
            if (r_v4) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end

            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_restart) begin
                            r_cnt  <= '0;
                            r_penv <= ENV_ONE;
                            r_vbit <= '0;
                        end
                        if (cnt_start >= r_note_len) begin
                            r_res_sample <= '0;
                            r_res_done   <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_FACT;
                        end
                    end
                end
                S_FACT: begin
                    r_factor <= FLAT30 + 31'(fac_prod[53:30]);
                    r_state  <= S_FS;
                end
                S_FS: begin
                    r_fs    <= fs_prod[53:30];
                    r_acc   <= '0;
                    r_iss   <= 1'b1;
                    r_k     <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (!r_iss && !r_v1 && !r_v2 && !r_v3 && !r_v4) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_neg   <= r_acc[ACC_W-1];
                    r_mag35 <= acc_abs[49:15];
                    r_att   <= att_now;
                    r_rel   <= rel_now;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_mag   <= gain_prod[47:16];
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_div_n  <= r_mag;
                    r_div_ph <= 1'b0;
                    if (r_att) begin
                        r_div_fac <= FW'(r_cnt);
                        r_div_den <= FW'(ATTACK_SAMPLES);
                        r_div_rcp <= ATT_RCP;
                        r_state   <= S_DQ;
                    end else if (r_rel) begin
                        r_div_fac <= FW'(rel_diff);
                        r_div_den <= FW'(RELEASE_SAMPLES);
                        r_div_rcp <= REL_RCP;
                        r_state   <= S_DQ;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_DQ: begin
                    r_div_q <= est_prod[63:32];
                    r_state <= S_DR;
                end
                S_DR: begin
                    if (!r_div_ph) begin
                        r_div_a <= div_q;
                        r_div_b <= div_r;
                        r_state <= S_DM;
                    end else begin
                        r_mag <= r_div_hi + div_q;
                        if (r_att) begin
                            r_att <= 1'b0;
                        end else begin
                            r_rel <= 1'b0;
                        end
                        r_state <= S_SEL;
                    end
                end
                S_DM: begin
                    r_div_hi <= hi_prod[MAG_W-1:0];
                    r_div_n  <= MAG_W'(lo_prod);
                    r_div_ph <= 1'b1;
                    r_state  <= S_DQ;
                end
                S_ROUND: begin
                    r_res_sample <= n_res_sample;
                    r_res_done   <= 1'b0;
                    r_penv       <= pitch_prod[62:32];
                    r_cnt        <= r_cnt + 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_sample    <= r_res_sample;
                        r_done      <= r_res_done;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PSAS_ASSERT_IMPL(a_wr_in_sweep, i_clk, i_rst_n, r_v2, r_state == S_RUN)
    `PSAS_ASSERT_IMPL(a_div_rem, i_clk, i_rst_n, r_state == S_DR, div_rem < ((MAG_W+1)'(r_div_den) << 1))
    `PSAS_ASSERT_NEXT(a_restart_clr, i_clk, i_rst_n, in_accept && i_restart, r_vbit == '0)
    `PSAS_ASSERT_NEXT(a_acc_clr, i_clk, i_rst_n, r_state == S_FS, r_acc == '0)

endmodule
`default_nettype wire
